### hw/rtl/tkl_pkg.sv
// Shared types and constants for the top-k largest-degree tracker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tkl_pkg;

    localparam int ID_W         = 10;
    localparam int DEG_W        = 16;
    localparam int CNT_W        = 5;
    localparam int MAX_KEPT_DEF = 16;
    localparam int NODE_COUNT   = 1024;

    // APB register map: one register, byte address 0
    localparam int  APB_ADDR_W     = 3;
    localparam int  APB_DATA_W     = 32;
    localparam logic REG_COUNT_KEPT = 1'b0;

    // One kept slot
    typedef struct packed {
        logic             filled;
        logic [ID_W-1:0]  id;
        logic [DEG_W-1:0] degree;
    } entry_t;

    // Offer broadcast to every cell of the chain
    typedef struct packed {
        logic             ins;
        logic             clear;
        logic [ID_W-1:0]  id;
        logic [DEG_W-1:0] degree;
    } offer_t;

endpackage

`default_nettype wire

### hw/rtl/tkl_in_if.sv
// Input channel of the tracker: valid/ready plus one offered node per beat.
// Depends on tkl_pkg.
`default_nettype none

interface tkl_in_if;
    import tkl_pkg::*;

    logic             valid;
    logic             ready;
    logic [ID_W-1:0]  node_id;
    logic [DEG_W-1:0] degree;
    logic             last_item;

    modport source (output valid, output node_id, output degree, output last_item,
                    input ready);
    modport sink   (input valid, input node_id, input degree, input last_item,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/tkl_out_if.sv
// Output channel of the tracker: valid/ready plus one ranked slot per beat.
// Depends on tkl_pkg.
`default_nettype none

interface tkl_out_if;
    import tkl_pkg::*;

    logic             valid;
    logic             ready;
    logic [ID_W-1:0]  ranked_id;
    logic [DEG_W-1:0] ranked_degree;
    logic             slot_empty;
    logic             last_result;

    modport source (output valid, output ranked_id, output ranked_degree,
                    output slot_empty, output last_result, input ready);
    modport sink   (input valid, input ranked_id, input ranked_degree,
                    input slot_empty, input last_result, output ready);
endinterface

`default_nettype wire

### hw/rtl/top_k_largest_degree_tracker_top.sv
// Top level of the top-k largest-degree tracker: insertion chain, readout chain, APB register.
// Depends on tkl_pkg, tkl_in_if, tkl_out_if, tkl_cell, tkl_drain_cell.
//
//  port      | dir  | beat carries
//  ----------+------+--------------------------------------------------
//  in_ch     | sink | node_id, degree, last_item
//  out_ch    | src  | ranked_id, ranked_degree, slot_empty, last_result
//  APB       | slv  | count_kept at byte address 0
//
// Cycles: one input beat per cycle unless a last_item beat stalls; each beat with node_id below
//   NODE_COUNT is compared against all kept slots in parallel and inserted in the same cycle.
// A last_item beat snapshots the list into the readout chain, which drains
//   min(count_kept, MAX_KEPT) beats (one per cycle while out_ch.ready is high),
//   rank 0 first, and clears the main list.
// Reset clears the list, the readout chain and count_kept at once.
// Non-last beats are taken while the readout drains; a last_item beat stalls
//   until the readout chain is empty or hands over its final beat.
`default_nettype none

module top_k_largest_degree_tracker_top #(
    parameter int MAX_KEPT = tkl_pkg::MAX_KEPT_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    tkl_in_if.sink                               in_ch,
    tkl_out_if.source                            out_ch,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tkl_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [tkl_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [tkl_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);
    import tkl_pkg::*;

    // Wide enough for MAX_KEPT itself and for the raw register value
    localparam int KW = ($clog2(MAX_KEPT + 1) > CNT_W) ? $clog2(MAX_KEPT + 1) : CNT_W;

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] count_kept_reg;
    logic [CNT_W-1:0] count_kept_next;
    logic             reg_sel;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[APB_ADDR_W-1];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        count_kept_next = count_kept_reg;
        if (cfg_write && (reg_sel == REG_COUNT_KEPT))
        begin
            count_kept_next = pwdata[CNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel == REG_COUNT_KEPT)
        begin
            prdata = APB_DATA_W'(count_kept_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_kept_reg <= '0;
        end
        else
        begin
            count_kept_reg <= count_kept_next;
        end
    end

    // Clamp the count to the chain length
    logic [KW-1:0] active_k;
    assign active_k = (KW'(count_kept_reg) > KW'(MAX_KEPT)) ? KW'(MAX_KEPT)
                                                            : KW'(count_kept_reg);

    // ---------------------------------------------------------------
    // Handshake control
    // ---------------------------------------------------------------
    logic [KW-1:0] remain_reg;
    logic [KW-1:0] remain_next;
    logic          in_fire;
    logic          out_fire;
    logic          drain_free;
    logic          load;
    logic          id_in_range;

    assign out_fire   = out_ch.valid && out_ch.ready;
    // Readout chain can take a snapshot this cycle
    assign drain_free = (remain_reg == '0) || ((remain_reg == KW'(1)) && out_fire);
    assign in_ch.ready = !in_ch.last_item || drain_free;
    assign in_fire    = in_ch.valid && in_ch.ready;
    assign load       = in_fire && in_ch.last_item;

    assign id_in_range = (17'(in_ch.node_id) < 17'(NODE_COUNT));

    always_comb
    begin
        priority if (load)
        begin
            remain_next = active_k;
        end
        else if (out_fire)
        begin
            remain_next = remain_reg - KW'(1);
        end
        else
        begin
            remain_next = remain_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= '0;
        end
        else
        begin
            remain_reg <= remain_next;
        end
    end

    // ---------------------------------------------------------------
    // Insertion chain: broadcast the offer, ripple the "found" flag
    // ---------------------------------------------------------------
    offer_t         offer;
    entry_t         cell_entry [MAX_KEPT];
    entry_t         cell_ins   [MAX_KEPT];
    entry_t         drain_entry[MAX_KEPT];
    logic [MAX_KEPT:0] found;

    assign offer.ins    = in_fire && id_in_range;
    assign offer.clear  = load;
    assign offer.id     = in_ch.node_id;
    assign offer.degree = in_ch.degree;
    assign found[0]     = 1'b0;

    for (genvar i = 0; i < MAX_KEPT; i++)
    begin : g_chain
        entry_t up_entry;
        entry_t down_entry;

        if (i == 0)
        begin : g_head
            assign up_entry = '0;
        end
        else
        begin : g_body
            assign up_entry = cell_entry[i-1];
        end

        if (i == MAX_KEPT - 1)
        begin : g_tail
            assign down_entry = '0;
        end
        else
        begin : g_mid
            assign down_entry = drain_entry[i+1];
        end

        tkl_cell #(
            .IDX (i),
            .KW  (KW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .offer     (offer),
            .active_k  (active_k),
            .up_entry  (up_entry),
            .found_in  (found[i]),
            .found_out (found[i+1]),
            .entry     (cell_entry[i]),
            .entry_ins (cell_ins[i])
        );

        // Snapshot after insertion, drain toward rank 0
        tkl_drain_cell u_drain (
            .clk        (clk),
            .rst_n      (rst_n),
            .load       (load),
            .shift      (out_fire),
            .load_entry (cell_ins[i]),
            .down_entry (down_entry),
            .entry      (drain_entry[i])
        );
    end

    // ---------------------------------------------------------------
    // Output beat straight from the head of the readout chain
    // ---------------------------------------------------------------
    assign out_ch.valid         = (remain_reg != '0);
    assign out_ch.ranked_id     = drain_entry[0].filled ? drain_entry[0].id : '0;
    assign out_ch.ranked_degree = drain_entry[0].filled ? drain_entry[0].degree : '0;
    assign out_ch.slot_empty    = !drain_entry[0].filled;
    assign out_ch.last_result   = (remain_reg == KW'(1));

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_readout_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (active_k != '0)) |=> out_ch.valid)
        else $error("readout did not start after a last item");

    a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> !cell_entry[0].filled)
        else $error("list not cleared after a last item");

    for (genvar j = 0; j + 1 < MAX_KEPT; j++)
    begin : g_sorted
        a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
            cell_entry[j].degree >= cell_entry[j+1].degree)
            else $error("kept list out of order");
    end

endmodule

`default_nettype wire

### hw/rtl/tkl_cell.sv
// One rank slot of the sorted insertion chain.
// Depends on tkl_pkg (entry_t, offer_t).
`default_nettype none

module tkl_cell #(
    parameter int IDX = 0,
    parameter int KW  = 5
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tkl_pkg::offer_t offer,
    input  wire logic [KW-1:0]   active_k,
    input  wire tkl_pkg::entry_t up_entry,
    input  wire logic            found_in,
    output logic                 found_out,
    output tkl_pkg::entry_t      entry,
    output tkl_pkg::entry_t      entry_ins
);
    import tkl_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   active;
    logic   hit;

    assign active    = KW'(IDX) < active_k;
    assign hit       = offer.ins && active && (offer.degree > entry_reg.degree);
    assign found_out = found_in || hit;

    // Shift down behind the insertion point, take the new node at it, else hold; a clear empties the slot
    always_comb
    begin
        entry_ins = entry_reg;
        if (offer.ins && active && found_in)
        begin
            entry_ins = up_entry;
        end
        else if (hit)
        begin
            entry_ins.filled = 1'b1;
            entry_ins.id     = offer.id;
            entry_ins.degree = offer.degree;
        end
        entry_next = offer.clear ? '0 : entry_ins;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

### hw/rtl/tkl_drain_cell.sv
// One slot of the readout chain: loads a snapshot, then shifts toward rank 0.
// Depends on tkl_pkg (entry_t).
`default_nettype none

module tkl_drain_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load,
    input  wire logic            shift,
    input  wire tkl_pkg::entry_t load_entry,
    input  wire tkl_pkg::entry_t down_entry,
    output tkl_pkg::entry_t      entry
);
    import tkl_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        priority if (load)
        begin
            entry_next = load_entry;
        end
        else if (shift)
        begin
            entry_next = down_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire
